// File: src/bswt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswt_pkg
// Shared constants and beat types for the binary search word table.
// ----------------------------------------------------------------------------
package bswt_pkg;

  // Default sizing of the table
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int WORD_BYTES_DEF  = 8;

  // Fixed field widths of the beats
  localparam int IDX_W   = 12;
  localparam int WORD_W  = 64;
  localparam int RANGE_W = 13;
  localparam int POS_W   = 12;

  // Action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic               action;
    logic [IDX_W-1:0]   entry_index;
    logic [WORD_W-1:0]  word;
    logic [RANGE_W-1:0] range_first;
    logic [RANGE_W-1:0] range_end;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_beat_t;

endpackage

// File: src/bswt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswt_mem
// Single-port synchronous word store with a registered read.
// ----------------------------------------------------------------------------
module bswt_mem #(
  parameter int DEPTH = bswt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(bswt_pkg::TABLE_DEPTH_DEF),
  parameter int DW    = 8 * bswt_pkg::WORD_BYTES_DEF
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic          re,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/bswt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswt_ctrl
// Search sequencer: takes write and search beats, walks the probe sequence
// against the word store, with a read state and a compare state per probe.
// ----------------------------------------------------------------------------
module bswt_ctrl #(
  parameter int TABLE_DEPTH = bswt_pkg::TABLE_DEPTH_DEF,
  parameter int WORD_BYTES  = bswt_pkg::WORD_BYTES_DEF,
  parameter int AW          = $clog2(bswt_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bswt_pkg::in_beat_t    in_beat,
  output logic [AW-1:0]         mem_addr,
  output logic                  mem_we,
  output logic                  mem_re,
  output logic [8*WORD_BYTES-1:0] mem_wdata,
  input  logic [8*WORD_BYTES-1:0] mem_rdata,
  output logic                  res_valid,
  output bswt_pkg::out_beat_t   res,
  input  logic                  res_take
);

  localparam int KW    = 8 * WORD_BYTES;
  localparam int DEP_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = (DEP_W > bswt_pkg::RANGE_W) ? DEP_W : bswt_pkg::RANGE_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state;
  logic [SW-1:0]               lo;       // lowest index still in play
  logic [SW-1:0]               hi_x;     // one past the highest index in play
  logic [KW-1:0]               key;
  logic [AW-1:0]               mid;
  logic                        found;
  logic [bswt_pkg::POS_W-1:0]  position;

  logic                        in_fire;
  logic [SW-1:0]               end_ext;
  logic [SW-1:0]               end_clamp;
  logic [SW:0]                 mid_sum;
  logic [AW-1:0]               mid_next;
  logic                        range_open;
  logic [KW-1:0]               probe;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && (state == S_IDLE);

  // Clamp the end of the range to the table depth
  assign end_ext   = SW'(in_beat.range_end);
  assign end_clamp = (end_ext > DEPTH_S) ? DEPTH_S : end_ext;

  // Midpoint floor((lo + hi) / 2) with hi = hi_x - 1
  assign mid_sum    = {1'b0, lo} + {1'b0, hi_x} - {{SW{1'b0}}, 1'b1};
  assign mid_next   = mid_sum[AW:1];
  assign range_open = (lo < hi_x);
  assign probe      = mem_rdata[KW-1:0];

  // Store port: writes while idle, probe reads while searching
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(in_beat.entry_index);
    mem_wdata = in_beat.word[KW-1:0];
    if (in_fire && (in_beat.action == bswt_pkg::ACT_WRITE)) begin
      mem_we = (SW'(in_beat.entry_index) < DEPTH_S);
    end else if ((state == S_READ) && range_open) begin
      mem_re   = 1'b1;
      mem_addr = mid_next;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && (in_beat.action == bswt_pkg::ACT_SEARCH)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= range_open ? S_CMP : S_DONE;
        end
        S_CMP: begin
          state <= (key == probe) ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        lo   <= SW'(in_beat.range_first);
        hi_x <= end_clamp;
        key  <= in_beat.word[KW-1:0];
      end
      S_READ: begin
        mid <= mid_next;
        if (!range_open) begin
          found    <= 1'b0;
          position <= '0;
        end
      end
      S_CMP: begin
        if (key == probe) begin
          found    <= 1'b1;
          position <= bswt_pkg::POS_W'(mid);
        end else if (key < probe) begin
          hi_x <= SW'(mid);
        end else begin
          lo <= SW'(mid) + SW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res_valid    = (state == S_DONE);
  assign res.found    = found;
  assign res.position = position;

endmodule

// File: src/binary_search_word_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_word_table
// Sorted word table with binary search lookup.
// ----------------------------------------------------------------------------
// A write beat stores one word and gives no result. A search beat runs a
// binary search over [range_first, range_end), with the end clamped to
// TABLE_DEPTH, comparing the low 8*WORD_BYTES bits as an unsigned value.
// Each probe has a read step, which reads the word store through its single
// port, and a compare step, which compares and narrows the range. A search
// keeps the input stalled until its result has moved into an output
// register, so the next beat may be taken while the result waits there.
// Searched entries must have been written beforehand.
// ----------------------------------------------------------------------------
module binary_search_word_table #(
  parameter int TABLE_DEPTH = bswt_pkg::TABLE_DEPTH_DEF,
  parameter int WORD_BYTES  = bswt_pkg::WORD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bswt_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output bswt_pkg::out_beat_t out_beat
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = 8 * WORD_BYTES;

  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic                mem_re;
  logic [KW-1:0]       mem_wdata;
  logic [KW-1:0]       mem_rdata;
  logic                res_valid;
  bswt_pkg::out_beat_t res;
  logic                res_take;

  bswt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_BYTES  (WORD_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .mem_addr  (mem_addr),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  bswt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (KW)
  ) u_mem (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .re    (mem_re),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output register: loads when empty or when its beat is taken
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_beat <= res;
    end
  end

endmodule

// File: src/bswt_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswt_check
// Port-level checks for the binary search word table, bound to the top.
// ----------------------------------------------------------------------------
module bswt_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input bswt_pkg::in_beat_t  in_beat,
  input logic                out_valid,
  input logic                out_stall,
  input bswt_pkg::out_beat_t out_beat
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // A miss always reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_beat.found |-> out_beat.position == '0)
    else $error("miss with non-zero position");

  // A write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_beat.action == bswt_pkg::ACT_WRITE)
      |=> !$rose(out_valid))
    else $error("result appeared after a write beat");

  // A search holds off the input while it runs
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_beat.action == bswt_pkg::ACT_SEARCH) |=> in_stall)
    else $error("input taken during a search");

endmodule

bind binary_search_word_table bswt_check u_check (.*);

// File: verif/tb_binary_search_word_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_search_word_table
// Self-checking bench for the binary search word table.
// ----------------------------------------------------------------------------
// Beats are queued up front. Most of the queue is made of short table segments
// that are written and then searched over ranges that lie inside written
// entries, so no search ever probes an unwritten entry. A behavioural lookup
// of its own predicts each search result as the beat is taken, and the
// results leaving the block are compared against those predictions in order.
// Both sides idle in short random bursts. The receiver also holds off once
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_binary_search_word_table;

  localparam int          DEPTH          = bswt_pkg::TABLE_DEPTH_DEF;
  localparam logic [63:0] KEY_MASK       = (bswt_pkg::WORD_BYTES_DEF == 8) ? '1 :
                                           ((64'd1 << (8 * bswt_pkg::WORD_BYTES_DEF)) - 64'd1);
  localparam int          BEAT_TARGET    = 650;
  localparam int          QUIET_TAIL     = 60;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          WATCHDOG_LIMIT = 3000;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bswt_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bswt_pkg::out_beat_t out_beat;

  // Beats waiting to be driven, search results still owed by the block
  bswt_pkg::in_beat_t  pending_beats[$];
  bswt_pkg::out_beat_t owed_results[$];

  // Generator view: which entries will have been written by the queued beats
  bit        gen_written[DEPTH];
  int        gen_count = 0;

  // Lookup-side copy of the word store, updated as beats are taken
  logic [63:0] table_image[DEPTH];

  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  int results_seen = 0;
  int mismatches = 0;
  int writes_taken = 0;
  int searches_taken = 0;
  int empty_ranges = 0;
  int hits_seen = 0;

  binary_search_word_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Expected outcome of a search against the current table image
  function automatic bswt_pkg::out_beat_t lookup_key(logic [63:0] key_in, int first,
                                                     int stop);
    bswt_pkg::out_beat_t res;
    logic [63:0]         key;
    logic [63:0]         probe;
    int                  lo;
    int                  hi;
    int                  mid;
    res = '0;
    key = key_in & KEY_MASK;
    lo  = first;
    hi  = ((stop > DEPTH) ? DEPTH : stop) - 1;
    while (lo <= hi) begin
      mid   = (lo + hi) / 2;
      probe = table_image[mid] & KEY_MASK;
      if (probe == key) begin
        res.found    = 1'b1;
        res.position = mid[bswt_pkg::POS_W-1:0];
        lo = hi + 1;
      end else if (key < probe) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  // True when every entry of the clamped range has been written (or it is empty)
  function automatic bit range_written(int first, int stop);
    int lim;
    lim = (stop > DEPTH) ? DEPTH : stop;
    for (int i = first; i < lim; i++)
      if (!gen_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_write(int idx, logic [63:0] w);
    bswt_pkg::in_beat_t b;
    b             = '0;
    b.action      = bswt_pkg::ACT_WRITE;
    b.entry_index = idx[bswt_pkg::IDX_W-1:0];
    b.word        = w;
    b.range_first = bswt_pkg::RANGE_W'($urandom);
    b.range_end   = bswt_pkg::RANGE_W'($urandom);
    pending_beats.push_back(b);
    gen_written[idx] = 1'b1;
    gen_count++;
  endtask

  task automatic queue_search(logic [63:0] key, int first, int stop);
    bswt_pkg::in_beat_t b;
    b             = '0;
    b.action      = bswt_pkg::ACT_SEARCH;
    b.entry_index = bswt_pkg::IDX_W'($urandom);
    b.word        = key;
    b.range_first = first[bswt_pkg::RANGE_W-1:0];
    b.range_end   = stop[bswt_pkg::RANGE_W-1:0];
    pending_beats.push_back(b);
    gen_count++;
  endtask

  // Stimulus, then drain and report
  initial begin
    logic [63:0] seg_words[$];
    logic [63:0] w;
    logic [63:0] span;
    logic [63:0] key;
    int          base;
    int          len;
    int          first;
    int          stop;
    int          pick;
    bit          sorted_seg;
    bit          descending;

    // Directed: word and index extremes, clamped end, empty ranges, single entry
    queue_write(0, 64'h0);
    queue_write(1, 64'h5);
    queue_write(2, 64'h8000_0000_0000_0000);
    queue_write(3, '1);
    queue_write(DEPTH - 2, 64'hA);
    queue_write(DEPTH - 1, '1);
    queue_search(64'h0, 0, 4);
    queue_search('1, 0, 4);
    queue_search(64'h8000_0000_0000_0000, 0, 4);
    queue_search(64'h3, 0, 4);
    queue_search('1, DEPTH - 2, 8191);
    queue_search(64'hA, DEPTH - 2, DEPTH + 1);
    queue_search(64'h0, DEPTH, DEPTH);
    queue_search('1, 8191, 8191);
    queue_search(64'h5, 3, 1);
    queue_search(64'h8000_0000_0000_0000, 2, 2);
    queue_search(64'h5, 1, 2);
    // Unsorted entries: the probe order alone decides the outcome
    queue_write(5, 64'd100);
    queue_write(6, 64'd1);
    queue_write(7, 64'd50);
    queue_search(64'd1, 5, 8);
    queue_search(64'd100, 5, 8);

    // Random: write a segment, then search inside it
    while (gen_count < BEAT_TARGET) begin
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 80);
      base = ($urandom_range(0, 7) == 0) ? DEPTH - len : $urandom_range(0, DEPTH - len);
      sorted_seg = ($urandom_range(0, 6) != 0);
      descending = $urandom_range(0, 1);
      seg_words.delete();
      if (!sorted_seg) begin
        for (int i = 0; i < len; i++) seg_words.push_back(rand_word());
      end else if ($urandom_range(0, 2) == 0) begin
        // clustered words with small gaps and duplicates
        w = rand_word();
        if (w > 64'hFFFF_FFFF_FFFF_FE00) w = w - 64'h200;
        for (int i = 0; i < len; i++) begin
          seg_words.push_back(w);
          w = w + 64'($urandom_range(0, 3));
        end
      end else begin
        span = 64'hFFFF_FFFF_FFFF_FFFF / 64'(len);
        for (int i = 0; i < len; i++)
          seg_words.push_back(64'(i) * span + (rand_word() % span));
      end
      for (int i = 0; i < len; i++) begin
        pick = descending ? len - 1 - i : i;
        queue_write(base + pick, seg_words[pick]);
      end

      repeat ($urandom_range(2, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          first = base;
          stop  = base + len;
          if (stop == DEPTH && $urandom_range(0, 1)) stop = $urandom_range(DEPTH, 8191);
        end else if (pick < 9) begin
          first = base + $urandom_range(0, len);
          stop  = base + $urandom_range(0, len);
        end else begin
          first = $urandom_range(0, 8191);
          stop  = $urandom_range(0, 8191);
          if (!range_written(first, stop)) first = $urandom_range(DEPTH, 8191);
        end
        pick = $urandom_range(0, 9);
        key  = seg_words[$urandom_range(0, len - 1)];
        if (pick >= 8) key = rand_word();
        else if (pick >= 5) key = $urandom_range(0, 1) ? key + 64'd1 : key - 64'd1;
        queue_search(key, first, stop);
      end

      // stray write that breaks the ordering of whatever sits there
      if ($urandom_range(0, 9) == 0) queue_write($urandom_range(0, DEPTH - 1), rand_word());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (owed_results.size() != 0) mismatches++;
    $display("Coverage: %0d writes, %0d searches (%0d empty ranges), %0d results, %0d hits.",
             writes_taken, searches_taken, empty_ranges, results_seen, hits_seen);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Driver: one beat per handshake, random idle bursts until the tail
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() != 0) begin
        if (pending_beats.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 3);
        end else begin
          in_beat  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: one long hold-off, otherwise short bursts until the tail
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 40) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (pending_beats.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Prediction on every taken input beat
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (in_beat.action == bswt_pkg::ACT_WRITE) begin
        table_image[in_beat.entry_index] = in_beat.word;
        writes_taken++;
      end else begin
        owed_results.push_back(lookup_key(in_beat.word, in_beat.range_first,
                                          in_beat.range_end));
        searches_taken++;
        if (in_beat.range_first >= ((in_beat.range_end > DEPTH) ? DEPTH : in_beat.range_end))
          empty_ranges++;
      end
    end
  end

  // Monitor: each result beat against the oldest prediction
  always @(posedge clk) begin
    bswt_pkg::out_beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (out_beat.found) hits_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result found=%0b position=%0d",
                   $realtime, out_beat.found, out_beat.position);
      end else begin
        exp_beat = owed_results.pop_front();
        if (out_beat.found !== exp_beat.found || out_beat.position !== exp_beat.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp found=%0b pos=%0d got found=%0b pos=%0d",
                     $realtime, exp_beat.found, exp_beat.position,
                     out_beat.found, out_beat.position);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
src/bswt_pkg.sv
src/bswt_mem.sv
src/bswt_ctrl.sv
src/binary_search_word_table.sv
src/bswt_check.sv
verif/tb_binary_search_word_table.sv
